// ===== rtl/brp_pkg.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser: shared definitions
// Widths, character codes, action and command codes, and the structs that
// pass between the parser, the string store and the top level.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int MaxIds  = 8;
  localparam int IdChars = 32;

  localparam int SlotW   = 3;   // indexes MaxIds slots
  localparam int PosW    = 5;   // indexes IdChars characters
  localparam int FillW   = 6;   // holds 0 .. IdChars
  localparam int IdCntW  = 4;   // holds 0 .. MaxIds
  localparam int IdAddrW = SlotW + PosW;
  localparam int IdDepth = MaxIds * IdChars;

  localparam int InDataW  = 24;
  localparam int InUserW  = 3;
  localparam int OutDataW = 40;

  localparam logic [7:0] ChDone  = 8'h44;  // 'D'
  localparam logic [7:0] ChOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChClose = 8'h5D;  // ']'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChLf    = 8'h0A;  // line feed

  typedef enum logic [1:0] {
    ActByte  = 2'd0,
    ActArm   = 2'd1,
    ActClear = 2'd2,
    ActRead  = 2'd3
  } brp_action_e;

  localparam logic [2:0] CmdInventory = 3'd0;
  localparam logic [2:0] CmdBlkRead   = 3'd1;
  localparam logic [2:0] CmdBlkWrite  = 3'd2;
  localparam logic [2:0] CmdCountOn   = 3'd3;
  localparam logic [2:0] CmdCountOff  = 3'd4;

  typedef struct packed {
    brp_action_e       action;
    logic [7:0]        rx_byte;
    logic [2:0]        command;
    logic              read_source;
    logic [SlotW-1:0]  slot;
    logic [PosW-1:0]   position;
  } brp_item_t;

  typedef struct packed {
    logic [IdCntW-1:0] uid_count;
    logic [7:0]        data_count;
    logic [7:0]        line_feeds;
    logic              inventory_active;
    logic              read_active;
    logic              write_active;
    logic              in_block;
  } brp_status_t;

  // Store updates requested by the parser for one step.
  typedef struct packed {
    logic               id_we;
    logic [IdAddrW-1:0] id_addr;
    logic               buf_we;
    logic [PosW-1:0]    buf_addr;
    logic [7:0]         wdata;
    logic               len_we;
    logic [SlotW-1:0]   len_slot;
    logic [FillW-1:0]   len_val;
    logic               dlen_we;
    logic [FillW-1:0]   dlen_val;
    logic               clr_lens;
  } brp_wr_t;

  typedef struct packed {
    logic             en;
    logic             src;
    logic [SlotW-1:0] slot;
    logic [PosW-1:0]  pos;
  } brp_rd_t;

endpackage

// ===== rtl/reader_bracket_response_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser
// Parses the bracketed replies of a tag reader under an armed command and
// answers reads of the stored tag IDs and block data.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (lowest bit up)                    | tuser
//  s_axis   | in        | rx_byte, command, slot, position         | action, read_source
//  m_axis   | out       | uid_count, data_count, line_feeds,       | -
//           |           | inventory/read/write active, in_block,   |
//           |           | read_char, read_length                   |
//
// An item passes from transfer to result through the input register, where the parser
// and the store update and the memory read is issued, and then through the result
// register, which takes the registered memory read data.
// One item is accepted every cycle while m_axis_tready is high.
// A stall on m_axis holds both stages; s_axis_tready falls only when both are full.
// Reset clears flags, counters and stored lengths; ID and buffer characters
// are undefined until written.
module reader_bracket_response_parser_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // rx_byte[7:0], command[10:8], slot[13:11], position[18:14], zero fill
  input  logic [brp_pkg::InDataW-1:0]    s_axis_tdata,
  // action[1:0], read_source[2]
  input  logic [brp_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // uid_count[3:0], data_count[11:4], line_feeds[19:12], inventory_active[20],
  // read_active[21], write_active[22], in_block[23], read_char[31:24],
  // read_length[37:32], zero fill
  output logic [brp_pkg::OutDataW-1:0]   m_axis_tdata
);
  import brp_pkg::*;

  logic        in_valid_q;
  brp_item_t   in_item_q;
  logic        out_valid_q;
  brp_status_t out_status_q;

  logic        advance;
  logic        step;
  brp_item_t   s_item;
  brp_status_t status_nxt;
  brp_wr_t     wr;
  brp_rd_t     rd;
  logic [7:0]  read_char;
  logic [5:0]  read_length;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  assign s_item.action      = brp_action_e'(s_axis_tuser[1:0]);
  assign s_item.read_source = s_axis_tuser[2];
  assign s_item.rx_byte     = s_axis_tdata[7:0];
  assign s_item.command     = s_axis_tdata[10:8];
  assign s_item.slot        = s_axis_tdata[13:11];
  assign s_item.position    = s_axis_tdata[18:14];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q  <= s_axis_tvalid;
      if (advance)       out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_item_q <= s_item;
    if (step) out_status_q <= status_nxt;
  end

  brp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .status_o (status_nxt),
    .wr_o     (wr),
    .rd_o     (rd)
  );

  brp_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .wr_i          (wr),
    .rd_i          (rd),
    .read_char_o   (read_char),
    .read_length_o (read_length)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          read_length,
                          read_char,
                          out_status_q.in_block,
                          out_status_q.write_active,
                          out_status_q.read_active,
                          out_status_q.inventory_active,
                          out_status_q.line_feeds,
                          out_status_q.data_count,
                          out_status_q.uid_count};

endmodule

// ===== rtl/brp_parser.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser: command flags and bracket parser
// Holds the armed-command flags, the block fill state and the counters, and
// works out the next state and the store updates for one item.
// ----------------------------------------------------------------------------
module brp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  brp_pkg::brp_item_t  item_i,
  output brp_pkg::brp_status_t status_o,
  output brp_pkg::brp_wr_t    wr_o,
  output brp_pkg::brp_rd_t    rd_o
);
  import brp_pkg::*;

  logic              inv_q, inv_d;
  logic              rdf_q, rdf_d;
  logic              wrf_q, wrf_d;
  logic              cnt_q, cnt_d;
  logic              open_q, open_d;
  logic              comma_q, comma_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [IdCntW-1:0] ids_q, ids_d;
  logic [7:0]        blks_q, blks_d;
  logic [7:0]        lines_q, lines_d;

  logic any_cmd;
  logic ids_room;
  logic fill_room;
  logic [7:0] b;

  assign b         = item_i.rx_byte;
  assign any_cmd   = inv_q | rdf_q | wrf_q;
  assign ids_room  = ids_q < IdCntW'(MaxIds);
  assign fill_room = fill_q < FillW'(IdChars);

  always_comb begin
    inv_d   = inv_q;
    rdf_d   = rdf_q;
    wrf_d   = wrf_q;
    cnt_d   = cnt_q;
    open_d  = open_q;
    comma_d = comma_q;
    fill_d  = fill_q;
    ids_d   = ids_q;
    blks_d  = blks_q;
    lines_d = lines_q;
    wr_o          = '0;
    wr_o.wdata    = b;
    wr_o.id_addr  = {ids_q[SlotW-1:0], fill_q[PosW-1:0]};
    wr_o.buf_addr = fill_q[PosW-1:0];
    wr_o.len_slot = ids_q[SlotW-1:0];
    wr_o.len_val  = fill_q;
    wr_o.dlen_val = fill_q;

    unique case (item_i.action)
      ActByte: begin
        if (any_cmd) begin
          priority if (b == ChDone && !open_q) begin
            inv_d = 1'b0;
          end else if (b == ChOpen) begin
            fill_d  = '0;
            open_d  = 1'b1;
            comma_d = 1'b0;
          end else if (b == ChClose && ids_room && open_q) begin
            if (rdf_q) begin
              wr_o.dlen_we = 1'b1;
              if (blks_q != 8'hFF) blks_d = blks_q + 8'd1;
            end else if (!comma_q && !wrf_q) begin
              wr_o.len_we = 1'b1;
              ids_d = ids_q + IdCntW'(1);
            end
            open_d = 1'b0;
            rdf_d  = 1'b0;
            wrf_d  = 1'b0;
          end else if (open_q && fill_room && ids_room) begin
            if (rdf_q) begin
              wr_o.buf_we = 1'b1;
              fill_d = fill_q + FillW'(1);
            end else if (!wrf_q) begin
              wr_o.id_we = 1'b1;
              if (fill_q == '0) comma_d = (b == ChComma);
              fill_d = fill_q + FillW'(1);
            end
          end else begin
            // Text outside a block, an overflowing block or a full store.
            fill_d = '0;
            open_d = 1'b0;
          end
        end else if (cnt_q && b == ChLf && lines_q != 8'hFF) begin
          lines_d = lines_q + 8'd1;
        end
      end
      ActArm: begin
        unique case (item_i.command)
          CmdInventory: inv_d = 1'b1;
          CmdBlkRead:   rdf_d = 1'b1;
          CmdBlkWrite:  wrf_d = 1'b1;
          CmdCountOn:   cnt_d = 1'b1;
          CmdCountOff:  cnt_d = 1'b0;
          default:      ;
        endcase
      end
      ActClear: begin
        ids_d         = '0;
        blks_d        = '0;
        lines_d       = '0;
        wr_o.clr_lens = 1'b1;
      end
      ActRead: ;
      default: ;
    endcase
  end

  assign rd_o.en   = (item_i.action == ActRead);
  assign rd_o.src  = item_i.read_source;
  assign rd_o.slot = item_i.slot;
  assign rd_o.pos  = item_i.position;

  assign status_o.uid_count        = ids_d;
  assign status_o.data_count       = blks_d;
  assign status_o.line_feeds       = lines_d;
  assign status_o.inventory_active = inv_d;
  assign status_o.read_active      = rdf_d;
  assign status_o.write_active     = wrf_d;
  assign status_o.in_block         = open_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= 1'b0;
      rdf_q   <= 1'b0;
      wrf_q   <= 1'b0;
      cnt_q   <= 1'b0;
      open_q  <= 1'b0;
      comma_q <= 1'b0;
      fill_q  <= '0;
      ids_q   <= '0;
      blks_q  <= '0;
      lines_q <= '0;
    end else if (step_i) begin
      inv_q   <= inv_d;
      rdf_q   <= rdf_d;
      wrf_q   <= wrf_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
      comma_q <= comma_d;
      fill_q  <= fill_d;
      ids_q   <= ids_d;
      blks_q  <= blks_d;
      lines_q <= lines_d;
    end
  end

endmodule

// ===== rtl/brp_store.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser: string store
// Tag ID memory, block data buffer and their lengths, with a registered
// read port that delivers the requested character and length.
// ----------------------------------------------------------------------------
module brp_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  brp_pkg::brp_wr_t wr_i,
  input  brp_pkg::brp_rd_t rd_i,
  output logic [7:0]       read_char_o,
  output logic [5:0]       read_length_o
);
  import brp_pkg::*;

  logic [7:0]       id_mem  [IdDepth];
  logic [7:0]       buf_mem [IdChars];
  logic [FillW-1:0] id_len_q [MaxIds];
  logic [FillW-1:0] dlen_q;

  logic [7:0]       id_rdata_q;
  logic [7:0]       buf_rdata_q;
  logic             src_q;
  logic             hit_q;
  logic [FillW-1:0] rlen_q;

  logic [FillW-1:0] rlen;
  logic             hit;

  always_comb begin
    rlen = '0;
    if (rd_i.en) begin
      if (rd_i.src) begin
        rlen = dlen_q;
      end else if (int'(rd_i.slot) < MaxIds) begin
        rlen = id_len_q[rd_i.slot];
      end
    end
  end

  assign hit = ({1'b0, rd_i.pos} < rlen) && (int'(rd_i.pos) < IdChars);

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (wr_i.id_we)  id_mem[wr_i.id_addr]   <= wr_i.wdata;
      if (wr_i.buf_we) buf_mem[wr_i.buf_addr] <= wr_i.wdata;
      id_rdata_q  <= id_mem[{rd_i.slot, rd_i.pos}];
      buf_rdata_q <= buf_mem[rd_i.pos];
      src_q       <= rd_i.src;
      rlen_q      <= rlen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxIds; i++) id_len_q[i] <= '0;
      dlen_q <= '0;
      hit_q  <= 1'b0;
    end else if (step_i) begin
      hit_q <= hit;
      if (wr_i.clr_lens) begin
        for (int i = 0; i < MaxIds; i++) id_len_q[i] <= '0;
      end else if (wr_i.len_we) begin
        id_len_q[wr_i.len_slot] <= wr_i.len_val;
      end
      if (wr_i.dlen_we) dlen_q <= wr_i.dlen_val;
    end
  end

  assign read_char_o   = hit_q ? (src_q ? buf_rdata_q : id_rdata_q) : 8'h00;
  assign read_length_o = 6'(rlen_q);

endmodule

// ===== dv/reader_bracket_response_parser_unit_chk.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser: stream checker
// Watches both stream channels, keeps its own copy of the parser flags,
// counters and string stores, works out the status word that each accepted
// input transfer should give and compares it field by field with the words
// that leave the block.
// ----------------------------------------------------------------------------
module reader_bracket_response_parser_unit_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [brp_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [brp_pkg::InUserW-1:0]  s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [brp_pkg::OutDataW-1:0] m_axis_tdata,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           words_o,
  output int                           ids_o,
  output int                           blocks_o
);

  import brp_pkg::*;

  // Status word in the m_axis tdata layout, highest bits first.
  typedef struct packed {
    logic [1:0]        pad;
    logic [FillW-1:0]  read_length;
    logic [7:0]        read_char;
    logic              in_block;
    logic              write_active;
    logic              read_active;
    logic              inventory_active;
    logic [7:0]        line_feeds;
    logic [7:0]        data_count;
    logic [IdCntW-1:0] uid_count;
  } status_word_t;

  logic              inv_on, rd_on, wr_on, lines_on, blk_open, comma_first;
  logic [FillW-1:0]  fill;
  logic [IdCntW-1:0] id_cnt;
  logic [7:0]        blk_cnt, lf_cnt;
  logic [7:0]        id_chr [IdDepth];
  logic [FillW-1:0]  id_len [MaxIds];
  logic [7:0]        buf_chr [IdChars];
  logic [FillW-1:0]  buf_len;

  status_word_t status_due_q[$];
  status_word_t want, got;
  brp_item_t    tap;

  // Applies one input item to the parser copy and returns the status word.
  function automatic status_word_t parse_step(input brp_item_t it);
    status_word_t w;
    logic [7:0]   b;
    w = '0;
    b = it.rx_byte;
    case (it.action)
      ActByte: begin
        if (inv_on || rd_on || wr_on) begin
          if (b == ChDone && !blk_open) begin
            inv_on = 1'b0;
          end else if (b == ChOpen) begin
            fill        = '0;
            blk_open    = 1'b1;
            comma_first = 1'b0;
          end else if (b == ChClose && id_cnt < IdCntW'(MaxIds) && blk_open) begin
            if (rd_on) begin
              buf_len = fill;
              if (blk_cnt != 8'hFF) blk_cnt++;
              blocks_o++;
            end else if (!comma_first && !wr_on) begin
              id_len[id_cnt[SlotW-1:0]] = fill;
              id_cnt++;
              ids_o++;
            end
            blk_open = 1'b0;
            rd_on    = 1'b0;
            wr_on    = 1'b0;
          end else if (blk_open && fill < FillW'(IdChars) && id_cnt < IdCntW'(MaxIds)) begin
            if (rd_on) begin
              buf_chr[fill[PosW-1:0]] = b;
              fill++;
            end else if (!wr_on) begin
              id_chr[{id_cnt[SlotW-1:0], fill[PosW-1:0]}] = b;
              if (fill == '0) comma_first = (b == ChComma);
              fill++;
            end
          end else begin
            // Text outside a block, an overflow or a full store rewinds the fill.
            fill     = '0;
            blk_open = 1'b0;
          end
        end else if (lines_on && b == ChLf && lf_cnt != 8'hFF) begin
          lf_cnt++;
        end
      end
      ActArm: begin
        case (it.command)
          CmdInventory: inv_on   = 1'b1;
          CmdBlkRead:   rd_on    = 1'b1;
          CmdBlkWrite:  wr_on    = 1'b1;
          CmdCountOn:   lines_on = 1'b1;
          CmdCountOff:  lines_on = 1'b0;
          default: ;
        endcase
      end
      ActClear: begin
        id_cnt  = '0;
        blk_cnt = '0;
        lf_cnt  = '0;
        foreach (id_len[i]) id_len[i] = '0;
      end
      default: begin
        if (it.read_source) begin
          w.read_length = buf_len;
          if ({1'b0, it.position} < buf_len) w.read_char = buf_chr[it.position];
        end else begin
          w.read_length = id_len[it.slot];
          if ({1'b0, it.position} < id_len[it.slot])
            w.read_char = id_chr[{it.slot, it.position}];
        end
      end
    endcase
    w.uid_count        = id_cnt;
    w.data_count       = blk_cnt;
    w.line_feeds       = lf_cnt;
    w.inventory_active = inv_on;
    w.read_active      = rd_on;
    w.write_active     = wr_on;
    w.in_block         = blk_open;
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count_o++;
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_on       = 1'b0;
      rd_on        = 1'b0;
      wr_on        = 1'b0;
      lines_on     = 1'b0;
      blk_open     = 1'b0;
      comma_first  = 1'b0;
      fill         = '0;
      id_cnt       = '0;
      blk_cnt      = '0;
      lf_cnt       = '0;
      buf_len      = '0;
      foreach (id_len[i]) id_len[i] = '0;
      foreach (id_chr[i]) id_chr[i] = '0;
      foreach (buf_chr[i]) buf_chr[i] = '0;
      status_due_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_o      = 0;
      ids_o        = 0;
      blocks_o     = 0;
    end else begin
      // The result side goes first: a word leaving now belongs to an earlier transfer.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_due_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: status word expected none, actual 0x%0h", $time, m_axis_tdata);
        end else begin
          want = status_due_q.pop_front();
          check_field("uid_count", 32'(want.uid_count), 32'(got.uid_count));
          check_field("data_count", 32'(want.data_count), 32'(got.data_count));
          check_field("line_feeds", 32'(want.line_feeds), 32'(got.line_feeds));
          check_field("inventory_active", 32'(want.inventory_active),
                      32'(got.inventory_active));
          check_field("read_active", 32'(want.read_active), 32'(got.read_active));
          check_field("write_active", 32'(want.write_active), 32'(got.write_active));
          check_field("in_block", 32'(want.in_block), 32'(got.in_block));
          check_field("read_char", 32'(want.read_char), 32'(got.read_char));
          check_field("read_length", 32'(want.read_length), 32'(got.read_length));
          check_field("zero fill", 32'(want.pad), 32'(got.pad));
          words_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tap.action      = brp_action_e'(s_axis_tuser[1:0]);
        tap.read_source = s_axis_tuser[2];
        tap.rx_byte     = s_axis_tdata[7:0];
        tap.command     = s_axis_tdata[10:8];
        tap.slot        = s_axis_tdata[13:11];
        tap.position    = s_axis_tdata[18:14];
        status_due_q.push_back(parse_step(tap));
      end
      pending_o = status_due_q.size();
    end
  end

endmodule

// ===== dv/reader_bracket_response_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Reader bracket response parser: testbench top
// Drives reader bytes, command arming, counter clears and store reads into
// the parser with bursty input and an irregular output stall, then leaves
// the checking to the stream checker and reports the verdict.
// ----------------------------------------------------------------------------
module reader_bracket_response_parser_unit_tb;

  import brp_pkg::*;

  localparam int IdleLimit     = 2000;
  localparam int HoldOffCycles = 120;
  localparam int SettleCycles  = 8;
  localparam int RandomItems   = 220;

  // Command codes above CmdCountOff are accepted and ignored.
  localparam logic [2:0] CmdUnusedTop = 3'd7;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxMostly,
    RxPeriodic
  } rx_pattern_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count, pending, words_checked, ids_taken, blocks_done;
  int items_sent     = 0;
  int burst_left     = 0;
  int hold_off_asked = 0;
  int idle_cycles    = 0;
  bit maybe_open     = 1'b0;

  always #5 clk_i = ~clk_i;

  reader_bracket_response_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  reader_bracket_response_parser_unit_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .words_o       (words_checked),
    .ids_o         (ids_taken),
    .blocks_o      (blocks_done)
  );

  // Fields that the action does not use are left random.
  function automatic brp_item_t rand_item();
    brp_item_t it;
    it.action      = brp_action_e'($urandom_range(0, 3));
    it.rx_byte     = 8'($urandom_range(0, 255));
    it.command     = 3'($urandom_range(0, 7));
    it.read_source = 1'($urandom_range(0, 1));
    it.slot        = SlotW'($urandom_range(0, 7));
    it.position    = PosW'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic brp_item_t mk_byte(input logic [7:0] b);
    brp_item_t it;
    it         = rand_item();
    it.action  = ActByte;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic brp_item_t mk_arm(input logic [2:0] cmd);
    brp_item_t it;
    it         = rand_item();
    it.action  = ActArm;
    it.command = cmd;
    return it;
  endfunction

  function automatic brp_item_t mk_clear();
    brp_item_t it;
    it        = rand_item();
    it.action = ActClear;
    return it;
  endfunction

  function automatic brp_item_t mk_read(input logic src, input logic [SlotW-1:0] sl,
                                        input logic [PosW-1:0] pos);
    brp_item_t it;
    it             = rand_item();
    it.action      = ActRead;
    it.read_source = src;
    it.slot        = sl;
    it.position    = pos;
    return it;
  endfunction

  function automatic logic [7:0] block_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == ChOpen || c == ChClose) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic int block_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 94) return $urandom_range(7, 31);
    return $urandom_range(32, 40);
  endfunction

  // One transfer on s_axis, with bursts and gaps between them.
  task automatic present(input brp_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 8);
    end
    s_axis_tdata  = {5'b0, it.position, it.slot, it.command, it.rx_byte};
    s_axis_tuser  = {it.read_source, it.action};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
    if (it.action == ActByte && it.rx_byte == ChOpen) maybe_open = 1'b1;
    if (it.action == ActByte && it.rx_byte == ChClose) maybe_open = 1'b0;
  endtask

  // A clear or a block-read arm in the middle of a block would let a later
  // read reach characters that were never stored, so the block is closed first.
  task automatic offer(input brp_item_t it);
    if (maybe_open && (it.action == ActClear ||
                       (it.action == ActArm && it.command == CmdBlkRead)))
      present(mk_byte(ChClose));
    present(it);
  endtask

  task automatic send_block(input bit arm, input logic [2:0] cmd, input int n,
                            input bit lead_comma, input bit closed);
    if (arm) offer(mk_arm(cmd));
    offer(mk_byte(ChOpen));
    for (int i = 0; i < n; i++)
      offer(mk_byte((i == 0 && lead_comma) ? ChComma : block_char()));
    if (closed) offer(mk_byte(ChClose));
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    burst_left = 0;
  endtask

  // Receiver: changing stall patterns, and a long hold-off when asked.
  initial begin
    int          served, mode_left, tick;
    rx_pattern_e mode;
    served    = 0;
    mode_left = 0;
    tick      = 0;
    mode      = RxOpen;
    forever begin
      @(negedge clk_i);
      if (served != hold_off_asked) begin
        served        = hold_off_asked;
        m_axis_tready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_pattern_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        tick++;
        case (mode)
          RxOpen:   m_axis_tready = 1'b1;
          RxCoin:   m_axis_tready = 1'($urandom_range(0, 1));
          RxMostly: m_axis_tready = ($urandom_range(0, 3) != 0);
          default:  m_axis_tready = ((tick % 5) > 1);
        endcase
      end
    end
  end

  // Watchdog on transfers in either direction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("** reader_bracket_response_parser_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int mix_end, pick, n;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty store reads, line counting, empty and comma blocks,
    // end of inventory, command priority, ignored code and clear.
    offer(mk_read(1'b0, 3'd7, 5'd31));
    offer(mk_read(1'b1, 3'd0, 5'd31));
    offer(mk_arm(CmdCountOn));
    offer(mk_byte(ChLf));
    offer(mk_arm(CmdCountOff));
    offer(mk_byte(ChLf));
    offer(mk_arm(CmdInventory));
    offer(mk_byte(ChOpen));
    offer(mk_byte(ChClose));
    offer(mk_byte(ChOpen));
    offer(mk_byte(ChComma));
    offer(mk_byte(ChDone));
    offer(mk_byte(ChClose));
    offer(mk_byte(ChOpen));
    offer(mk_byte(8'hFF));
    offer(mk_byte(8'h00));
    offer(mk_byte(ChClose));
    offer(mk_byte(ChDone));
    offer(mk_arm(CmdBlkRead));
    offer(mk_arm(CmdBlkWrite));
    offer(mk_byte(ChOpen));
    offer(mk_byte(8'h5A));
    offer(mk_byte(ChClose));
    offer(mk_read(1'b0, 3'd1, 5'd0));
    offer(mk_read(1'b0, 3'd1, 5'd1));
    offer(mk_read(1'b1, 3'd0, 5'd0));
    offer(mk_arm(CmdUnusedTop));
    offer(mk_clear());
    drain();

    // Random mix; it opens with a long receiver hold-off while input keeps coming.
    hold_off_asked++;
    burst_left = 200;
    mix_end    = items_sent + RandomItems;
    while (items_sent < mix_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_block($urandom_range(0, 9) < 6, CmdInventory, block_len(),
                   $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0);
      end else if (pick < 45) begin
        send_block(1'b1, CmdBlkRead, block_len(), 1'b0, $urandom_range(0, 9) != 0);
      end else if (pick < 53) begin
        send_block(1'b1, CmdBlkWrite, block_len(), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) != 0);
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 3))
          offer(mk_read(1'($urandom_range(0, 1)), SlotW'($urandom_range(0, 7)),
                        PosW'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 31))));
      end else if (pick < 73) begin
        offer(mk_byte(ChDone));
      end else if (pick < 78) begin
        offer(mk_arm(3'($urandom_range(0, 7))));
      end else if (pick < 83) begin
        offer(mk_arm(CmdCountOn));
        repeat ($urandom_range(1, 6))
          offer(mk_byte(($urandom_range(0, 3) != 0) ? ChLf : block_char()));
        if ($urandom_range(0, 1)) offer(mk_arm(CmdCountOff));
      end else if (pick < 86) begin
        offer(mk_clear());
      end else begin
        offer(mk_byte(8'($urandom_range(0, 255))));
      end
    end
    drain();

    // Drop every parse command so that line feeds are counted up to saturation.
    offer(mk_byte(ChClose));
    offer(mk_clear());
    offer(mk_byte(ChOpen));
    offer(mk_byte(ChClose));
    offer(mk_byte(ChDone));
    offer(mk_arm(CmdCountOn));
    repeat (300)
      offer(($urandom_range(0, 19) != 0) ? mk_byte(ChLf)
                                         : mk_byte(8'($urandom_range(0, 255))));

    // A run of short block reads with the odd buffer read between them.
    offer(mk_clear());
    repeat (20) begin
      send_block(1'b1, CmdBlkRead, ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(0, 1),
                 1'b0, 1'b1);
      if ($urandom_range(0, 7) == 0)
        offer(mk_read(1'b1, SlotW'($urandom_range(0, 7)), PosW'($urandom_range(0, 1))));
    end
    drain();

    $display("Run covered %0d input transfers and %0d status words: %0d tag IDs captured,",
             items_sent, words_checked, ids_taken);
    $display("%0d block reads completed, with counter saturation and a long output stall.",
             blocks_done);
    if (fail_count == 0)
      $display("** reader_bracket_response_parser_unit: PASSED **");
    else
      $display("** reader_bracket_response_parser_unit: FAILED **");
    $finish;
  end

endmodule
